// File: rtl/core/stq_pkg.sv
// stq_pkg: shared types and constants for the sorted timer queue
// depends on nothing; used by the channel interfaces and the top level

package stq_pkg;

	// most results one tick word may cause
	localparam int unsigned MAX_RESULTS = 16;

	typedef enum logic {
		FUNC_SCHED = 1'b0,
		FUNC_TICK  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STAT_SCHED = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_FIRED = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS,
		ST_RESP,
		ST_SCAN,
		ST_POP_RD,
		ST_POP
	} state_t;

endpackage

// File: rtl/core/stq_req_if.sv
// stq_req_if: request channel of the sorted timer queue (schedule and tick words)
// depends on stq_pkg

interface stq_req_if #(
	parameter int unsigned TIME_WIDTH = 32,
	parameter int unsigned ID_WIDTH   = 8
);
	import stq_pkg::*;

	logic                  valid;
	logic                  ready;
	func_t                 func;
	logic [ID_WIDTH-1:0]   task_id;
	logic [TIME_WIDTH-1:0] due_time;
	logic                  periodic;
	logic [TIME_WIDTH-1:0] repeat_interval;
	logic [TIME_WIDTH-1:0] now_time;

	modport source (
		output valid, func, task_id, due_time, periodic, repeat_interval, now_time,
		input  ready
	);
	modport sink (
		input  valid, func, task_id, due_time, periodic, repeat_interval, now_time,
		output ready
	);
endinterface

// File: rtl/core/stq_rsp_if.sv
// stq_rsp_if: result channel of the sorted timer queue
// depends on stq_pkg

interface stq_rsp_if #(
	parameter int unsigned ID_WIDTH = 8
);
	import stq_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [ID_WIDTH-1:0] fired_id;
	logic                last;

	modport source (
		output valid, status, fired_id, last,
		input  ready
	);
	modport sink (
		input  valid, status, fired_id, last,
		output ready
	);
endinterface

// File: rtl/core/sorted_timer_queue.sv
// sorted_timer_queue: timer list kept sorted by due time in one synchronous memory
// depends on stq_pkg, stq_req_if, stq_rsp_if

// The queue holds up to DEPTH tasks in a circular buffer in one memory, earliest due
// time at the head. A schedule word walks from the tail toward the head, moving every
// stored task due later than the new one back one place, then writes the new task and
// gives its result word; a full queue goes straight to its result word. A tick word
// first scans the head, one entry per cycle, to count the due tasks (at most 16), then
// fires them, each once the output register has room; a periodic task goes back in
// by the insertion walk at now plus its interval (saturating), and with no due task
// the tick gives one none result. A new word is taken only when the previous one is
// done, while its last result may still wait in the output register.

module sorted_timer_queue #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned TIME_WIDTH = 32,
	parameter int unsigned ID_WIDTH   = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	stq_req_if.sink  req,
	stq_rsp_if.source rsp
);
	import stq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned DW = $clog2(MAX_RESULTS + 1);
	localparam int unsigned NW = (CW > DW) ? CW : DW;
	localparam int unsigned SW = AW + 2;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] tm;
		logic [ID_WIDTH-1:0]   id;
		logic                  per;
		logic [TIME_WIDTH-1:0] iv;
	} entry_t;

	// task memory, one read and one write per cycle
	entry_t task_mem [DEPTH];
	entry_t rd_q;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;     // stored tasks
	logic [AW-1:0] head_q;      // physical slot of the earliest task
	logic [CW-1:0] j_q;         // insertion walk position, logical
	logic [NW-1:0] scan_q;      // due tasks found by the scan
	logic [DW-1:0] left_q;      // due tasks still to fire
	logic          from_tick_q; // insertion belongs to a tick

	entry_t                ent_q;     // task being inserted
	logic [TIME_WIDTH-1:0] now_q;
	status_t               code_q;    // pending single result
	logic [ID_WIDTH-1:0]   code_id_q;

	logic                  rsp_v_q;
	status_t               rsp_status_q;
	logic [ID_WIDTH-1:0]   rsp_id_q;
	logic                  rsp_last_q;

	logic                  accept;
	logic                  can_emit;
	logic                  ins_stop;
	logic                  scan_hit;
	logic [CW-1:0]         rd_l;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;
	logic                  emit;
	status_t               emit_status;
	logic [ID_WIDTH-1:0]   emit_id;
	logic                  emit_last;
	logic [TIME_WIDTH:0]   resched_sum;
	logic [TIME_WIDTH-1:0] resched_tm;

	// logical position from the head to a physical slot
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] l);
		logic [SW-1:0] s;
		s = SW'(head) + SW'(l);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign accept   = req.valid && req.ready;
	assign can_emit = !rsp_v_q || rsp.ready;

	// walk stops at the front or behind an entry due no later than the new one
	assign ins_stop = (j_q == '0) || (rd_q.tm <= ent_q.tm);
	assign scan_hit = (scan_q < NW'(count_q)) && (rd_q.tm <= now_q)
	                  && (scan_q < NW'(MAX_RESULTS));

	assign resched_sum = {1'b0, now_q} + {1'b0, rd_q.iv};
	assign resched_tm  = resched_sum[TIME_WIDTH] ? '1 : resched_sum[TIME_WIDTH-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.func == FUNC_TICK) begin
						state_d = ST_SCAN;
					end else if (count_q == CW'(DEPTH)) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_INS_RD: state_d = ST_INS;
			ST_INS: begin
				if (ins_stop) begin
					if (!from_tick_q) begin
						state_d = ST_RESP;
					end else if (left_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_POP_RD;
					end
				end
			end
			ST_RESP: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!scan_hit) begin
					state_d = (scan_q == '0) ? ST_RESP : ST_POP_RD;
				end
			end
			ST_POP_RD: state_d = ST_POP;
			ST_POP: begin
				if (can_emit) begin
					if (rd_q.per) begin
						state_d = ST_INS_RD;
					end else if (left_q == DW'(1)) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_POP_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: memory port control and result words
	always_comb begin
		req.ready   = 1'b0;
		rd_l        = '0;
		wr_en       = 1'b0;
		wr_addr     = phys(head_q, j_q);
		wr_data     = rd_q;
		emit        = 1'b0;
		emit_status = code_q;
		emit_id     = code_id_q;
		emit_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_INS_RD: rd_l = j_q - CW'(1);
			ST_INS: begin
				wr_en = 1'b1;
				if (ins_stop) begin
					wr_data = ent_q;
				end else begin
					rd_l = j_q - CW'(2);
				end
			end
			ST_RESP: emit = can_emit;
			ST_SCAN: rd_l = CW'(scan_q + NW'(1));
			ST_POP_RD: rd_l = '0;
			ST_POP: begin
				emit        = can_emit;
				emit_status = STAT_FIRED;
				emit_id     = rd_q.id;
				emit_last   = (left_q == DW'(1));
			end
			default: ;
		endcase
	end

	assign rd_addr = phys(head_q, rd_l);

	always_ff @(posedge clk) begin
		rd_q <= task_mem[rd_addr];
		if (wr_en) begin
			task_mem[wr_addr] <= wr_data;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			j_q         <= '0;
			scan_q      <= '0;
			left_q      <= '0;
			from_tick_q <= 1'b0;
			rsp_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						j_q         <= count_q;
						scan_q      <= '0;
						left_q      <= '0;
						from_tick_q <= (req.func == FUNC_TICK);
					end
				end
				ST_INS: begin
					if (ins_stop) begin
						count_q <= count_q + CW'(1);
					end else begin
						j_q <= j_q - CW'(1);
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						scan_q <= scan_q + NW'(1);
					end else begin
						left_q <= DW'(scan_q);
					end
				end
				ST_POP: begin
					if (can_emit) begin
						head_q  <= phys(head_q, CW'(1));
						count_q <= count_q - CW'(1);
						j_q     <= count_q - CW'(1);
						left_q  <= left_q - DW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= emit_status;
			rsp_id_q     <= emit_id;
			rsp_last_q   <= emit_last;
		end
		if (state_q == ST_IDLE && accept) begin
			ent_q.tm  <= req.due_time;
			ent_q.id  <= req.task_id;
			ent_q.per <= req.periodic;
			ent_q.iv  <= req.repeat_interval;
			now_q     <= req.now_time;
			code_id_q <= req.task_id;
			code_q    <= (count_q == CW'(DEPTH)) ? STAT_FULL : STAT_SCHED;
		end
		if (state_q == ST_SCAN && !scan_hit) begin
			code_q    <= STAT_NONE;
			code_id_q <= '0;
		end
		// periodic task goes back in at now plus its interval
		if (state_q == ST_POP && can_emit && rd_q.per) begin
			ent_q.tm  <= resched_tm;
			ent_q.id  <= rd_q.id;
			ent_q.per <= 1'b1;
			ent_q.iv  <= rd_q.iv;
		end
	end

	assign rsp.valid    = rsp_v_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.fired_id = rsp_id_q;
	assign rsp.last     = rsp_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("task count above depth");

	a_pop_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP || state_q == ST_POP_RD) |-> left_q != '0)
		else $error("pop with no due task left");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FUNC_SCHED && count_q == CW'(DEPTH))
		|=> count_q == $past(count_q))
		else $error("full queue changed on a dropped schedule");
`endif

endmodule
